>>> hw/rtl/fir_bp_pkg.sv
`default_nettype none

package fir_bp_pkg;

  localparam int unsigned MAX_TAPS = 64;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned OUT_W    = 18;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned SKIP_W   = 10;
  localparam int unsigned FRAC_SH  = 11;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(8000);
  localparam logic [SKIP_W-1:0] SKIP_RESET = '0;

  // Band-pass taps, Q1.15
  localparam logic signed [COEF_W-1:0] COEF_Q15 [MAX_TAPS] = '{
    -16'sd114,  16'sd19,    16'sd208,   16'sd466,   16'sd728,   16'sd850,
    16'sd670,   16'sd98,    -16'sd804,  -16'sd1797, -16'sd2528, -16'sd2655,
    -16'sd1997, -16'sd631,  16'sd1099,  16'sd2685,  16'sd3631,  16'sd3631,
    16'sd2685,  16'sd1099,  -16'sd631,  -16'sd1997, -16'sd2655, -16'sd2528,
    -16'sd1797, -16'sd804,  16'sd98,    16'sd670,   16'sd850,   16'sd728,
    16'sd466,   16'sd208,   16'sd19,    -16'sd114,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
  };

  typedef enum logic {
    REG_NOISE_THRESHOLD = 1'b0,
    REG_START_SKIP      = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

>>> hw/rtl/fir_bandpass_with_noise_check.sv
// 34-tap band-pass FIR with a noise check on each capture. One sample is taken
// every clock cycle when the result side keeps up; each result passes through the
// input register, then the transposed-form tap row, then the result register,
// before it is presented. The filter is built in transposed form: each accepted
// sample is multiplied by every constant tap at once and added into a row of
// partial sums, so the per-sample work is one constant multiply and one add per tap.
// The output carries 4 fractional bits, rounded half up and saturated to 18
// bits. over_threshold_o flags samples whose magnitude exceeds noise_threshold
// from position start_skip of the capture onward; capture_noisy_o is sticky
// until the next start_of_capture_i. Registers: noise_threshold at byte
// address 0 (reset 8000), start_skip at byte address 4 (reset 0).
`default_nettype none

module fir_bandpass_with_noise_check
  import fir_bp_pkg::*;
#(
  parameter int unsigned TAPS        = 34,
  parameter int unsigned CAPTURE_LEN = 1024,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]       adc_sample_i,
  input  wire logic                         start_of_capture_i,

  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic signed [OUT_W-1:0]      filtered_sample_o,
  output      logic                         over_threshold_o,
  output      logic                         capture_noisy_o,

  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ADDR_W-1:0]            paddr,
  input  wire logic [DATA_W-1:0]            pwdata,
  output      logic [DATA_W-1:0]            prdata,
  output      logic                         pready
);

  localparam int unsigned NT     = (TAPS > MAX_TAPS) ? MAX_TAPS : TAPS;
  localparam int unsigned PROD_W = SAMPLE_BITS + COEF_W + 1;
  localparam int unsigned ACC_W  = PROD_W + 6;
  localparam int unsigned IDX_W  = $clog2(CAPTURE_LEN);
  localparam int unsigned CMP_W  = (IDX_W > SKIP_W) ? IDX_W : SKIP_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPTURE_LEN - 1);
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1 << (FRAC_SH - 1));

  // configuration
  logic [THR_W-1:0]  thr_q;
  logic [SKIP_W-1:0] skip_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      skip_q <= SKIP_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NOISE_THRESHOLD: thr_q  <= pwdata[THR_W-1:0];
        REG_START_SKIP:      skip_q <= pwdata[SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NOISE_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, thr_q};
      REG_START_SKIP:      prdata = {{(DATA_W-SKIP_W){1'b0}}, skip_q};
      default:             prdata = '0;
    endcase
  end

  // pipeline flow control
  logic v0_q, v1_q, ov_q;
  logic rdy0, rdy1, rdy2;
  logic in_acc, fire1, fire2, out_acc;

  assign rdy2    = !ov_q || !out_stall_i;
  assign rdy1    = !v1_q || rdy2;
  assign rdy0    = !v0_q || rdy1;
  assign in_stall_o = !rdy0;
  assign in_acc  = in_valid_i && rdy0;
  assign fire1   = v0_q && rdy1;
  assign fire2   = v1_q && rdy2;
  assign out_acc = ov_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (in_acc) begin
        v0_q <= 1'b1;
      end else if (fire1) begin
        v0_q <= 1'b0;
      end
      if (fire1) begin
        v1_q <= 1'b1;
      end else if (fire2) begin
        v1_q <= 1'b0;
      end
      if (fire2) begin
        ov_q <= 1'b1;
      end else if (out_acc) begin
        ov_q <= 1'b0;
      end
    end
  end

  // input register
  logic [SAMPLE_BITS-1:0] x0_q;
  logic                   sop0_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x0_q   <= adc_sample_i;
      sop0_q <= start_of_capture_i;
    end
  end

  // transposed tap row
  logic signed [PROD_W-1:0] xs;
  logic signed [ACC_W-1:0]  tap_prod [NT];
  logic signed [ACC_W-1:0]  part_q   [NT-1];
  logic signed [ACC_W-1:0]  part_d   [NT-1];
  logic signed [ACC_W-1:0]  acc_d;

  assign xs = {{(PROD_W-SAMPLE_BITS){1'b0}}, x0_q};

  for (genvar g = 0; g < NT; g++) begin : g_tap
    logic signed [PROD_W-1:0] cext;
    logic signed [PROD_W-1:0] prod;
    assign cext = {{(PROD_W-COEF_W){COEF_Q15[g][COEF_W-1]}}, COEF_Q15[g]};
    assign prod = xs * cext;
    assign tap_prod[g] = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  always_comb begin
    for (int i = 0; i < NT - 2; i++) begin
      part_d[i] = tap_prod[i+1] + part_q[i+1];
    end
    part_d[NT-2] = tap_prod[NT-1] + RND;
  end

  assign acc_d = tap_prod[0] + part_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NT - 1; i++) begin
        part_q[i] <= RND;
      end
    end else if (fire1) begin
      for (int i = 0; i < NT - 1; i++) begin
        part_q[i] <= part_d[i];
      end
    end
  end

  // capture position
  logic [IDX_W-1:0] idx_q, idx_cur, idx_d;
  logic             chk_d;

  assign idx_cur = sop0_q ? '0 : idx_q;
  assign idx_d   = (idx_cur < IDX_LAST) ? idx_cur + IDX_W'(1) : IDX_LAST;
  assign chk_d   = CMP_W'(idx_cur) >= CMP_W'(skip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire1) begin
      idx_q <= idx_d;
    end
  end

  logic signed [ACC_W-1:0] acc1_q;
  logic                    chk1_q;
  logic                    sop1_q;

  always_ff @(posedge clk_i) begin
    if (fire1) begin
      acc1_q <= acc_d;
      chk1_q <= chk_d;
      sop1_q <= sop0_q;
    end
  end

  // round, saturate, threshold check
  logic                     ovf_hi, ovf_lo;
  logic signed [OUT_W-1:0]  y_d;
  logic signed [OUT_W:0]    y_ext, thr_pos;
  logic                     over_d;
  logic                     noisy_q, noisy_d;

  assign ovf_hi = !acc1_q[ACC_W-1] && (|acc1_q[ACC_W-2:FRAC_SH+OUT_W-1]);
  assign ovf_lo = acc1_q[ACC_W-1] && !(&acc1_q[ACC_W-2:FRAC_SH+OUT_W-1]);

  always_comb begin
    if (ovf_hi) begin
      y_d = {1'b0, {(OUT_W-1){1'b1}}};
    end else if (ovf_lo) begin
      y_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      y_d = acc1_q[FRAC_SH+OUT_W-1:FRAC_SH];
    end
  end

  assign y_ext   = {y_d[OUT_W-1], y_d};
  assign thr_pos = {{(OUT_W+1-THR_W){1'b0}}, thr_q};
  assign over_d  = chk1_q && ((y_ext > thr_pos) || (y_ext < -thr_pos));
  assign noisy_d = (sop1_q ? 1'b0 : noisy_q) | over_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noisy_q <= 1'b0;
    end else if (fire2) begin
      noisy_q <= noisy_d;
    end
  end

  logic signed [OUT_W-1:0] y_q;
  logic                    over_q;

  always_ff @(posedge clk_i) begin
    if (fire2) begin
      y_q    <= y_d;
      over_q <= over_d;
    end
  end

  assign out_valid_o       = ov_q;
  assign filtered_sample_o = y_q;
  assign over_threshold_o  = over_q;
  assign capture_noisy_o   = noisy_q;

  // checks
  a_noisy_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && over_q |-> noisy_q)
    else $error("over-threshold result without noisy flag");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_LAST)
    else $error("capture index past last position");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v0_q && v1_q && ov_q)
    else $error("input stalled with a free pipeline slot");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire2 |=> ov_q)
    else $error("result lost on advance to output register");

endmodule

`default_nettype wire

>>> bench/fir_bandpass_with_noise_check_test.sv
`timescale 1ns / 1ps

module fir_bandpass_with_noise_check_test;
  import fir_bp_pkg::*;

  localparam int NTAPS       = 34;
  localparam int CAPTURE_LEN = 1024;
  localparam int SAMPLE_BITS = 12;
  localparam int OUT_MAX     = 131071;
  localparam int OUT_MIN     = -131072;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DIRECTED_N  = 20;

  localparam logic [SAMPLE_BITS-1:0] DIRECTED_X [DIRECTED_N] = '{
    12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800,
    12'h7FF, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h800, 12'hFFF
  };
  // capture starts at the first sample and twice in a row mid-way
  localparam logic [DIRECTED_N-1:0] DIRECTED_SOC = 20'h03001;

  typedef enum int {
    SEQ_NOISE,
    SEQ_MATCH_POS,
    SEQ_MATCH_NEG,
    SEQ_LEVEL,
    SEQ_EXTREME
  } seq_kind_e;

  class filter_scoreboard;
    typedef struct {
      logic signed [OUT_W-1:0] sample;
      logic                    over;
      logic                    noisy;
    } filter_result_t;

    logic [SAMPLE_BITS-1:0] history [NTAPS-1];
    int unsigned            position;
    bit                     noisy;
    int                     threshold;
    int unsigned            skip;
    filter_result_t         expected_q [$];
    int                     errors;
    int                     samples_in;
    int                     results;
    int                     overs;
    int                     noisy_results;
    int unsigned            max_position;

    function new();
      foreach (history[i]) history[i] = '0;
      position      = 0;
      noisy         = 0;
      threshold     = int'(THR_RESET);
      skip          = 32'(SKIP_RESET);
      errors        = 0;
      samples_in    = 0;
      results       = 0;
      overs         = 0;
      noisy_results = 0;
      max_position  = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_NOISE_THRESHOLD: threshold = int'(value[THR_W-1:0]);
        REG_START_SKIP:      skip = 32'(value[SKIP_W-1:0]);
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [SAMPLE_BITS-1:0] x, logic soc);
      longint         acc;
      longint         y;
      bit             over;
      filter_result_t r;
      if (soc) begin
        position = 0;
        noisy    = 0;
      end
      acc = longint'(COEF_Q15[0]) * longint'(x);
      for (int k = 1; k < NTAPS; k++)
        acc += longint'(COEF_Q15[k]) * longint'(history[k-1]);
      y = (acc + 1024) >>> FRAC_SH;
      if (y > OUT_MAX) y = OUT_MAX;
      if (y < OUT_MIN) y = OUT_MIN;
      for (int k = NTAPS - 2; k > 0; k--)
        history[k] = history[k-1];
      history[0] = x;
      over  = (position >= skip) && (y > threshold || y < -threshold);
      noisy = noisy | over;
      if (position > max_position) max_position = position;
      if (position < CAPTURE_LEN - 1) position++;
      r.sample = y[OUT_W-1:0];
      r.over   = over;
      r.noisy  = noisy;
      expected_q.push_back(r);
      samples_in++;
    endfunction

    function void check_result(logic signed [OUT_W-1:0] s, logic o, logic n);
      filter_result_t e;
      results++;
      if (o === 1'b1) overs++;
      if (n === 1'b1) noisy_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d with no sample pending: sample %0d over %b noisy %b",
                   results, s, o, n);
        return;
      end
      e = expected_q.pop_front();
      if (s !== e.sample || o !== e.over || n !== e.noisy) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at result %0d: expected sample %0d over %b noisy %b, got %0d %b %b",
                   results, e.sample, e.over, e.noisy, s, o, n);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni             = 1'b0;
  logic                          in_valid_i         = 1'b0;
  logic                          in_stall_o;
  logic [SAMPLE_BITS-1:0]        adc_sample_i       = '0;
  logic                          start_of_capture_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i        = 1'b0;
  logic signed [OUT_W-1:0]       filtered_sample_o;
  logic                          over_threshold_o;
  logic                          capture_noisy_o;
  logic                          psel               = 1'b0;
  logic                          penable            = 1'b0;
  logic                          pwrite             = 1'b0;
  logic [ADDR_W-1:0]             paddr              = '0;
  logic [DATA_W-1:0]             pwdata             = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;

  filter_scoreboard sb = new();
  int in_gap_pct  = 20;
  int stall_pct   = 20;
  int stall_left  = 0;
  int cycle_count = 0;

  fir_bandpass_with_noise_check dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .adc_sample_i       (adc_sample_i),
    .start_of_capture_i (start_of_capture_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .filtered_sample_o  (filtered_sample_o),
    .over_threshold_o   (over_threshold_o),
    .capture_noisy_o    (capture_noisy_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int burst_len();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int pick_gap(int pct);
    return ($urandom_range(99) < pct) ? burst_len() : 0;
  endfunction

  // matched kinds line up full scale with the tap signs for a peak output
  function automatic logic [SAMPLE_BITS-1:0] shaped_sample(seq_kind_e kind, int j,
                                                           logic [SAMPLE_BITS-1:0] level);
    bit hi;
    int jitter;
    jitter = ($urandom_range(3) == 0) ? $urandom_range(0, 200) : 0;
    hi     = (j < NTAPS) && (COEF_Q15[NTAPS-1-j] > 0);
    case (kind)
      SEQ_MATCH_POS: return hi ? 12'(4095 - jitter) : 12'(jitter);
      SEQ_MATCH_NEG: return hi ? 12'(jitter) : 12'(4095 - jitter);
      SEQ_LEVEL:     return level;
      SEQ_EXTREME:   return $urandom_range(1) ? 12'hFFF : 12'h000;
      default:       return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0 && $urandom_range(99) < stall_pct) stall_left = burst_len();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(adc_sample_i, start_of_capture_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(filtered_sample_o, over_threshold_o, capture_noisy_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] x, input logic soc);
    int gap;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    adc_sample_i       <= x;
    start_of_capture_i <= soc;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain(input int extra);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic run_stream(input int count, input int soc_odds, input bit open_capture,
                            input int pause_at);
    int                     sent;
    int                     len;
    int                     r;
    seq_kind_e              kind;
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS-1:0] x;
    logic                   soc;
    sent = 0;
    while (sent < count) begin
      r     = $urandom_range(9);
      kind  = (r < 4) ? SEQ_NOISE : (r < 6) ? SEQ_MATCH_POS : (r < 8) ? SEQ_MATCH_NEG :
              (r == 8) ? SEQ_LEVEL : SEQ_EXTREME;
      len   = (kind == SEQ_MATCH_POS || kind == SEQ_MATCH_NEG) ? NTAPS : $urandom_range(4, 40);
      level = $urandom_range(0, 4095);
      for (int j = 0; j < len && sent < count; j++) begin
        x   = shaped_sample(kind, j, level);
        soc = (sent == 0) ? open_capture : (soc_odds > 0 && $urandom_range(soc_odds - 1) == 0);
        if (sent == pause_at) drain(0);
        send_sample(x, soc);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < DIRECTED_N; i++) send_sample(DIRECTED_X[i], DIRECTED_SOC[i]);
    drain(6);

    write_reg(REG_NOISE_THRESHOLD, 32'd0);
    write_reg(REG_START_SKIP, 32'd0);
    in_gap_pct = 0;
    stall_pct  = 0;
    run_stream(70, 15, 1'b1, -1);
    drain(6);

    write_reg(REG_NOISE_THRESHOLD, 32'd131071);
    in_gap_pct = 30;
    stall_pct  = 30;
    run_stream(60, 20, 1'b1, -1);
    drain(6);

    // one capture long enough to pin the position at its last index
    write_reg(REG_NOISE_THRESHOLD, 32'd6000);
    write_reg(REG_START_SKIP, 32'd1023);
    in_gap_pct = 10;
    stall_pct  = 15;
    run_stream(1100, 0, 1'b1, 550);
    drain(6);

    write_reg(REG_NOISE_THRESHOLD, DATA_W'($urandom_range(2000, 12000)));
    write_reg(REG_START_SKIP, DATA_W'($urandom_range(0, 40)));
    in_gap_pct = 40;
    stall_pct  = 40;
    run_stream(70, 12, 1'b1, -1);
    drain(6);

    write_reg(REG_NOISE_THRESHOLD, DATA_W'($urandom_range(0, 20000)));
    write_reg(REG_START_SKIP, DATA_W'($urandom_range(0, 1023)));
    in_gap_pct = 25;
    stall_pct  = 25;
    run_stream(80, 30, 1'b0, -1);
    drain(6);

    write_reg(REG_NOISE_THRESHOLD, 32'd1);
    write_reg(REG_START_SKIP, 32'd3);
    run_stream(50, 10, 1'b1, -1);
    drain(10);

    $display("%0d samples filtered, %0d results checked, %0d over threshold, %0d flagged noisy",
             sb.samples_in, sb.results, sb.overs, sb.noisy_results);
    $display("thresholds 0 to 131071, skip 0 to 1023, capture position reached %0d, %0d errors",
             sb.max_position, sb.errors + sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
